>>> src/snp_pkg.sv
// Shared constants and types for the segment nearest point core.
`default_nettype none
package snp_pkg;

	// Coordinate width of the registers and query fields
	localparam int COORD_BITS = 32;
	// Fraction bits of the projection ratio
	localparam int T_FRAC = 24;
	// Width of every coordinate port field
	localparam int FIELD_BITS = 32;

	typedef enum logic [1:0] {
		REGION_START    = 2'd0,
		REGION_END      = 2'd1,
		REGION_INTERIOR = 2'd2
	} region_t;

	// Per-item control carried along the pipeline
	typedef struct packed {
		logic    valid;
		region_t region;
	} tag_t;

	typedef enum logic [1:0] {
		CFG_START_X = 2'd0,
		CFG_START_Y = 2'd1,
		CFG_END_X   = 2'd2,
		CFG_END_Y   = 2'd3
	} cfg_index_t;

endpackage
`default_nettype wire

>>> src/segment_nearest_point_core.sv
// Top level: closest point on a configured 2D segment, fully pipelined.
//
// Channel   Dir  Fields (low bit first)
// s_axis    in   tdata: query_x[31:0], query_y[63:32]
// m_axis    out  tdata: near_x[31:0], near_y[63:32], region[65:64], zero pad
// cfg       in   cfg_we, cfg_addr (register index), cfg_data
//
// One query enters per cycle unless the output stalls. The pipeline has
// 30 register stages: the offset subtract, two multiply stages, the dot
// product sum, the classify stage, 24 one-bit divider stages and the output.
// Reset clears all valid bits and the segment registers to zero.
// When the output holds a result that is not taken, the whole pipeline
// freezes and s_axis_tready drops; nothing is lost or repeated.
`default_nettype none
module segment_nearest_point_core
	import snp_pkg::*;
#(
	parameter int COORD_W = COORD_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,  // query_x, query_y
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [71:0]      m_axis_tdata,  // near_x, near_y, region, pad
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [31:0] cfg_data
);

	localparam int VW = COORD_W + 1;
	localparam int PW = 2 * COORD_W + 2;
	localparam int RW = 2 * COORD_W + 3;
	localparam int OW = T_FRAC + VW;

	logic signed [COORD_W-1:0] ax_q, ay_q, bx_q, by_q;
	logic signed [VW-1:0]      vx, vy;
	logic        [VW-1:0]      vx_mag, vy_mag;
	logic                      en;

	// Segment registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q <= '0;
			ay_q <= '0;
			bx_q <= '0;
			by_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_addr))
				CFG_START_X: ax_q <= cfg_data[COORD_W-1:0];
				CFG_START_Y: ay_q <= cfg_data[COORD_W-1:0];
				CFG_END_X:   bx_q <= cfg_data[COORD_W-1:0];
				CFG_END_Y:   by_q <= cfg_data[COORD_W-1:0];
				default:     ;
			endcase
		end
	end

	// Segment direction; the user must keep it static while items are in flight, the block leaves this to the user
	assign vx     = VW'(bx_q) - VW'(ax_q);
	assign vy     = VW'(by_q) - VW'(ay_q);
	assign vx_mag = vx[VW-1] ? VW'(-vx) : vx;
	assign vy_mag = vy[VW-1] ? VW'(-vy) : vy;

	// Whole pipeline advances unless a result waits
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// Stage 1: offset from the start point
	logic signed [COORD_W-1:0] qx, qy;
	logic signed [VW-1:0]      wx_s1, wy_s1;
	logic                      valid_s1;
	assign qx = s_axis_tdata[COORD_W-1:0];
	assign qy = s_axis_tdata[32 +: COORD_W];

	// Stage 2: products; Stage 3: dot products; Stage 4: classify
	logic signed [PW-1:0] pwx_s2, pwy_s2, pvx_s2, pvy_s2;
	logic                 valid_s2;
	logic signed [RW-1:0] d_s3, s_s3;
	logic                 valid_s3;
	tag_t                 tag_s4;
	logic [RW-1:0]        rem_s4, den_s4;
	logic                 d_le0, d_ge;
	region_t              region_c;

	assign d_le0 = d_s3[RW-1] || (d_s3 == '0);
	assign d_ge  = $unsigned(d_s3) >= $unsigned(s_s3);
	always_comb begin
		priority if (d_le0) begin
			region_c = REGION_START;
		end else if (d_ge) begin
			region_c = REGION_END;
		end else begin
			region_c = REGION_INTERIOR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			tag_s4   <= '0;
		end else if (en) begin
			valid_s1      <= s_axis_tvalid;
			valid_s2      <= valid_s1;
			valid_s3      <= valid_s2;
			tag_s4.valid  <= valid_s3;
			tag_s4.region <= region_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1  <= VW'(qx) - VW'(ax_q);
			wy_s1  <= VW'(qy) - VW'(ay_q);
			pwx_s2 <= PW'(wx_s1) * PW'(vx);
			pwy_s2 <= PW'(wy_s1) * PW'(vy);
			pvx_s2 <= PW'(vx) * PW'(vx);
			pvy_s2 <= PW'(vy) * PW'(vy);
			d_s3   <= RW'(pwx_s2) + RW'(pwy_s2);
			s_s3   <= RW'(pvx_s2) + RW'(pvy_s2);
			rem_s4 <= (region_c == REGION_INTERIOR) ? d_s3 : '0;
			den_s4 <= s_s3;
		end
	end

	// Divider: one quotient bit per stage
	tag_t              div_tag [T_FRAC+1];
	logic [RW-1:0]     div_rem [T_FRAC+1];
	logic [RW-1:0]     div_den [T_FRAC+1];
	logic [T_FRAC-1:0] div_quo [T_FRAC+1];

	assign div_tag[0] = tag_s4;
	assign div_rem[0] = rem_s4;
	assign div_den[0] = den_s4;
	assign div_quo[0] = '0;

	for (genvar k = 0; k < T_FRAC; k++) begin : g_div
		snp_div_step #(.RW(RW)) u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.tag_i  (div_tag[k]),
			.rem_i  (div_rem[k]),
			.den_i  (div_den[k]),
			.quo_i  (div_quo[k]),
			.tag_o  (div_tag[k+1]),
			.rem_o  (div_rem[k+1]),
			.den_o  (div_den[k+1]),
			.quo_o  (div_quo[k+1])
		);
	end

	// Stage 5: scale direction magnitudes by the ratio
	tag_t          tag_s5;
	logic [OW-1:0] offx_s5, offy_s5;
	logic [VW-1:0] offx, offy;
	logic signed [VW-1:0]      lx, ly;
	logic signed [COORD_W-1:0] nx, ny;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s5 <= '0;
		end else if (en) begin
			tag_s5 <= div_tag[T_FRAC];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			offx_s5 <= OW'(div_quo[T_FRAC]) * OW'(vx_mag);
			offy_s5 <= OW'(div_quo[T_FRAC]) * OW'(vy_mag);
		end
	end

	// Truncate the offset and step from the start point
	assign offx = offx_s5[T_FRAC +: VW];
	assign offy = offy_s5[T_FRAC +: VW];
	assign lx   = vx[VW-1] ? VW'(ax_q) - offx : VW'(ax_q) + offx;
	assign ly   = vy[VW-1] ? VW'(ay_q) - offy : VW'(ay_q) + offy;

	always_comb begin
		unique case (tag_s5.region)
			REGION_START: begin
				nx = ax_q;
				ny = ay_q;
			end
			REGION_END: begin
				nx = bx_q;
				ny = by_q;
			end
			default: begin
				nx = lx[COORD_W-1:0];
				ny = ly[COORD_W-1:0];
			end
		endcase
	end

	// Output register
	logic signed [FIELD_BITS-1:0] near_x_q, near_y_q;
	region_t                      region_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= tag_s5.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			near_x_q <= FIELD_BITS'(nx);
			near_y_q <= FIELD_BITS'(ny);
			region_q <= tag_s5.region;
		end
	end

	assign m_axis_tdata = {6'b0, region_q, near_y_q, near_x_q};

endmodule
`default_nettype wire

>>> src/snp_div_step.sv
// One registered step of the restoring ratio divider.
`default_nettype none
module snp_div_step
	import snp_pkg::*;
#(
	parameter int RW = 2 * COORD_BITS + 3
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire tag_t              tag_i,
	input  wire logic [RW-1:0]     rem_i,
	input  wire logic [RW-1:0]     den_i,
	input  wire logic [T_FRAC-1:0] quo_i,
	output tag_t                   tag_o,
	output logic [RW-1:0]          rem_o,
	output logic [RW-1:0]          den_o,
	output logic [T_FRAC-1:0]      quo_o
);

	logic [RW-1:0] rem_sh;
	logic          take;

	// Shift in a zero, then trial-subtract the denominator
	assign rem_sh = {rem_i[RW-2:0], 1'b0};
	assign take   = rem_sh >= den_i;

	// Advance control on every enabled edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_o <= '0;
		end else if (en) begin
			tag_o <= tag_i;
		end
	end

	// Advance partial remainder and quotient
	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= take ? rem_sh - den_i : rem_sh;
			den_o <= den_i;
			quo_o <= {quo_i[T_FRAC-2:0], take};
		end
	end

endmodule
`default_nettype wire

>>> tb/segment_nearest_point_checker.sv
// Checker for the segment nearest point core: predicts each result and compares it.
`default_nettype none
module segment_nearest_point_checker
	import snp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,  // query_x, query_y
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [71:0] m_axis_tdata,  // near_x, near_y, region, pad
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [31:0] cfg_data,
	output int               fail_count,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [31:0] nx;
		logic [31:0] ny;
		region_t     reg_code;
	} nearest_t;

	logic signed [31:0] seg_ax, seg_ay, seg_bx, seg_by;
	nearest_t nearest_q[$];

	// Interpolate one coordinate: a + trunc(t * v / 2^24) with sign of v.
	function automatic logic signed [31:0] lerp_axis(logic signed [63:0] a,
			logic signed [63:0] v, logic [63:0] t);
		logic [63:0] mag_v;
		logic [63:0] off;
		mag_v = v < 0 ? -v : v;
		off = (t * mag_v) >> T_FRAC;
		return v < 0 ? 32'(a - $signed(off)) : 32'(a + $signed(off));
	endfunction

	// Closest point of the current segment to one query.
	function automatic nearest_t project_query(logic signed [31:0] px,
			logic signed [31:0] py);
		logic signed [63:0] vx, vy, wx, wy;
		logic signed [127:0] dot_wv, len_sq, rem;
		logic [63:0] t;
		nearest_t r;
		vx = 64'(seg_bx) - 64'(seg_ax);
		vy = 64'(seg_by) - 64'(seg_ay);
		wx = 64'(px) - 64'(seg_ax);
		wy = 64'(py) - 64'(seg_ay);
		dot_wv = 128'(wx) * 128'(vx) + 128'(wy) * 128'(vy);
		len_sq = 128'(vx) * 128'(vx) + 128'(vy) * 128'(vy);
		if (dot_wv <= 0) begin
			r.nx = seg_ax; r.ny = seg_ay; r.reg_code = REGION_START;
		end else if (dot_wv >= len_sq) begin
			r.nx = seg_bx; r.ny = seg_by; r.reg_code = REGION_END;
		end else begin
			rem = dot_wv;
			t = 0;
			for (int i = 0; i < T_FRAC; i++) begin
				rem = rem <<< 1;
				t = t << 1;
				if (rem >= len_sq) begin
					rem = rem - len_sq;
					t[0] = 1'b1;
				end
			end
			r.nx = lerp_axis(64'(seg_ax), vx, t);
			r.ny = lerp_axis(64'(seg_ay), vy, t);
			r.reg_code = REGION_INTERIOR;
		end
		return r;
	endfunction

	// Track registers, queue predictions, compare transfers.
	always @(posedge clk or negedge arst_n) begin
		nearest_t exp_r;
		if (!arst_n) begin
			seg_ax <= 0; seg_ay <= 0; seg_bx <= 0; seg_by <= 0;
			fail_count <= 0;
			pending <= 0;
			nearest_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index_t'(cfg_addr))
					CFG_START_X: seg_ax <= cfg_data;
					CFG_START_Y: seg_ay <= cfg_data;
					CFG_END_X:   seg_bx <= cfg_data;
					CFG_END_Y:   seg_by <= cfg_data;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				nearest_q.push_back(project_query(s_axis_tdata[31:0], s_axis_tdata[63:32]));
			if (m_axis_tvalid && m_axis_tready) begin
				if (nearest_q.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected result %h", m_axis_tdata);
				end else begin
					exp_r = nearest_q.pop_front();
					if (m_axis_tdata[31:0] !== exp_r.nx || m_axis_tdata[63:32] !== exp_r.ny
							|| m_axis_tdata[65:64] !== exp_r.reg_code) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("mismatch: exp x=%h y=%h r=%0d got x=%h y=%h r=%0d",
								exp_r.nx, exp_r.ny, exp_r.reg_code, m_axis_tdata[31:0],
								m_axis_tdata[63:32], m_axis_tdata[65:64]);
					end
				end
			end
			pending <= nearest_q.size();
		end
	end
endmodule
`default_nettype wire

>>> tb/segment_nearest_point_core_tb.sv
// Testbench top: stimulus, configuration phases and verdict for the core.
`default_nettype none
module segment_nearest_point_core_tb;
	import snp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 30;
	localparam int WATCHDOG = 2000;

	logic        clk, arst_n;
	logic        s_axis_tvalid, s_axis_tready;
	logic [63:0] s_axis_tdata;   // query_x, query_y
	logic        m_axis_tvalid, m_axis_tready;
	logic [71:0] m_axis_tdata;   // near_x, near_y, region, pad
	logic        cfg_we;
	logic [1:0]  cfg_addr;
	logic [31:0] cfg_data;
	int          fail_count, pending, idle_cycles;
	logic        hold_off;

	segment_nearest_point_core uut (.*);
	segment_nearest_point_checker chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Watchdog: count cycles without any transfer.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("segment_nearest_point_core regression: fail");
			$finish;
		end
	end

	// Receiver: random wait before each result, plus one long hold-off on request.
	initial begin
		int wait_n;
		m_axis_tready = 0;
		forever begin
			if (hold_off) begin
				m_axis_tready <= 0;
				repeat (200) @(posedge clk);
			end
			wait_n = $urandom_range(0, 7);
			if (wait_n > 0) begin
				m_axis_tready <= 0;
				repeat (wait_n) @(posedge clk);
			end
			m_axis_tready <= 1;
			do @(posedge clk); while (!m_axis_tvalid && !hold_off);
		end
	end

	task automatic write_reg(cfg_index_t idx, logic [31:0] value);
		cfg_we <= 1; cfg_addr <= idx; cfg_data <= value;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic set_segment(logic [31:0] ax, logic [31:0] ay, logic [31:0] bx,
			logic [31:0] by);
		write_reg(CFG_START_X, ax);
		write_reg(CFG_START_Y, ay);
		write_reg(CFG_END_X, bx);
		write_reg(CFG_END_Y, by);
	endtask

	// Offer one query, with a random gap before it unless no_gap is set.
	task automatic send_query(logic [31:0] qx, logic [31:0] qy, bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {qy, qx};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Wait until every expected result has come, then let the pipe drain.
	task automatic drain;
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord(int scale);
		case (scale)
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 'h1FFFFF)) - 'h100000);
			default: return 32'($signed($urandom_range(0, 'h3FF)) - 'h200);
		endcase
	endfunction

	localparam logic [31:0] MAXP = 32'h7FFFFFFF;
	localparam logic [31:0] MINN = 32'h80000000;

	initial begin
		int sc;
		logic [31:0] ax, ay, bx, by;
		arst_n = 0; s_axis_tvalid = 0; s_axis_tdata = 0;
		cfg_we = 0; cfg_addr = 0; cfg_data = 0; hold_off = 0; idle_cycles = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Zero-length segment at reset values.
		send_query(32'h00010000, 32'hFFFF0000, 0);
		send_query(MAXP, MINN, 0);
		drain();

		// Horizontal unit segment: start, end, interior, endpoints exactly.
		set_segment(0, 0, 32'h00010000, 0);
		send_query(32'hFFFF0000, 32'h00050000, 0);
		send_query(32'h00020000, 0, 1);
		send_query(32'h00008000, 32'h12345678, 1);
		send_query(0, 0, 0);
		send_query(32'h00010000, 0, 0);
		send_query(32'h00000001, 32'hFFFFFFFF, 0);
		send_query(32'h0000FFFF, 0, 0);
		drain();

		// Extreme diagonal segment spanning the whole range.
		set_segment(MINN, MINN, MAXP, MAXP);
		send_query(MAXP, MINN, 0);
		send_query(MINN, MAXP, 0);
		send_query(0, 0, 1);
		send_query(MAXP, MAXP, 1);
		send_query(MINN, MINN, 0);
		send_query(32'h12345678, 32'h87654321, 0);
		drain();

		// Reverse extreme with a zero-length segment at the max corner.
		set_segment(MAXP, MINN, MINN, MAXP);
		send_query(0, 0, 0);
		send_query(32'hFFFFFFFF, 32'h00000001, 0);
		send_query(MAXP, MAXP, 0);
		drain();
		set_segment(MAXP, MAXP, MAXP, MAXP);
		send_query(MINN, MINN, 0);
		drain();

		// Random phases, with one long receiver hold-off early on.
		for (int ph = 0; ph < 14; ph++) begin
			sc = ph % 3;
			ax = rand_coord(sc); ay = rand_coord(sc);
			bx = rand_coord(sc); by = rand_coord(sc);
			if (ph == 5) by = ay;
			set_segment(ax, ay, bx, by);
			for (int i = 0; i < 100; i++) begin
				if (ph == 1 && i == 3) hold_off <= 1;
				if (ph == 1 && i == 4) hold_off <= 0;
				if ($urandom_range(0, 3) == 0)
					send_query(rand_coord(0), rand_coord(0), $urandom_range(0, 2) == 0);
				else
					send_query(32'(ax + 32'($signed(rand_coord(sc)))),
						32'(ay + 32'($signed(rand_coord(sc)))), $urandom_range(0, 2) == 0);
			end
			drain();
		end

		if (fail_count == 0)
			$display("segment_nearest_point_core regression: pass");
		else
			$display("segment_nearest_point_core regression: fail");
		$finish;
	end
endmodule
`default_nettype wire

>>> segment_nearest_point_core.f
src/snp_pkg.sv
src/snp_div_step.sv
src/segment_nearest_point_core.sv
tb/segment_nearest_point_checker.sv
tb/segment_nearest_point_core_tb.sv
